### rtl/core/ris_pkg.sv
// ----------------------------------------------------------------------------
// ris_pkg
// Shared widths, codes and controller/datapath interface types for the
// record index sorter.
// ----------------------------------------------------------------------------
package ris_pkg;

  localparam int MAX_RECORDS_DEF = 1024;

  localparam int CMD_W    = 2;
  localparam int RC_W     = 16;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 10;
  localparam int IDXO_W   = 10;
  localparam int TOTAL_W  = 11;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 3;

  // commands
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SORT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // sort modes
  localparam logic [MODE_W-1:0] MODE_READ_FIRST = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MOMENTUM   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TIME_DESC  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TIME_ASC   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESET      = MODE_MOMENTUM;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_APPEND,
    OP_READ_ISSUE,
    OP_READ_DONE,
    OP_SORT_START,
    OP_INIT_WR,
    OP_P0_RD,
    OP_P0_WR,
    OP_OI_RD,
    OP_OI_KEY,
    OP_OI_LOAD,
    OP_J_RD,
    OP_J_KEY,
    OP_J_CMP,
    OP_I_WR,
    OP_SORT_DONE
  } ris_op_t;

  typedef struct packed {
    ris_op_t op;
  } ris_cmd_t;

  typedef struct packed {
    logic part;
    logic keyed;
    logic empty;
    logic one_rec;
    logic i_last;
    logic i_penult;
    logic j_last;
    logic pass;
  } ris_stat_t;

endpackage

### rtl/core/ris_ram.sv
// ----------------------------------------------------------------------------
// ris_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ris_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ris_datapath.sv
// ----------------------------------------------------------------------------
// ris_datapath
// Record stores, order store, loop counters, compare unit, mode register
// and result register of the record index sorter.
// ----------------------------------------------------------------------------
module ris_datapath #(
  parameter int MAX_RECORDS = ris_pkg::MAX_RECORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ris_pkg::MODE_W-1:0]    cfg_wdata,
  input  logic [ris_pkg::RC_W-1:0]      in_read_count,
  input  logic [ris_pkg::KEY_W-1:0]     in_momentum,
  input  logic [ris_pkg::KEY_W-1:0]     in_created_time,
  input  logic [ris_pkg::POS_W-1:0]     in_position,
  input  ris_pkg::ris_cmd_t             cmd,
  output ris_pkg::ris_stat_t            stat,
  output logic [ris_pkg::IDXO_W-1:0]    out_record_index,
  output logic [ris_pkg::TOTAL_W-1:0]   out_entry_total,
  output logic [ris_pkg::STATUS_W-1:0]  out_status
);

  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int CMP_W = (CNT_W > ris_pkg::POS_W) ? CNT_W : ris_pkg::POS_W;

  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [ris_pkg::MODE_W-1:0]    mode_r, mode_nxt;
  logic [CNT_W-1:0]              i_r, i_nxt;
  logic [CNT_W-1:0]              j_r, j_nxt;
  logic [CNT_W-1:0]              k_r, k_nxt;
  logic                          pass_r, pass_nxt;
  logic                          pos_bad_r, pos_bad_nxt;
  logic [IDX_W-1:0]              cur_idx_r, cur_idx_nxt;
  logic [ris_pkg::KEY_W-1:0]     cur_key_r, cur_key_nxt;
  logic [IDX_W-1:0]              cand_r, cand_nxt;
  logic [ris_pkg::IDXO_W-1:0]    oidx_r, oidx_nxt;
  logic [ris_pkg::TOTAL_W-1:0]   otot_r, otot_nxt;
  logic [ris_pkg::STATUS_W-1:0]  ost_r, ost_nxt;

  logic                          rec_we;
  logic [IDX_W-1:0]              rec_waddr;
  logic [IDX_W-1:0]              rc_raddr;
  logic [ris_pkg::RC_W-1:0]      rc_rdata;
  logic [IDX_W-1:0]              key_raddr;
  logic [ris_pkg::KEY_W-1:0]     mom_rdata;
  logic [ris_pkg::KEY_W-1:0]     time_rdata;
  logic                          ord_we;
  logic [IDX_W-1:0]              ord_waddr;
  logic [IDX_W-1:0]              ord_wdata;
  logic [IDX_W-1:0]              ord_raddr;
  logic [IDX_W-1:0]              ord_rdata;

  logic [ris_pkg::KEY_W-1:0]     key_sel;
  logic                          better;
  logic                          full;
  logic                          load;
  logic                          match;
  logic [CNT_W:0]                count_ext;
  logic [CNT_W:0]                i_ext;
  logic [CNT_W:0]                j_ext;

  ris_ram #(.WIDTH(ris_pkg::RC_W), .DEPTH(MAX_RECORDS)) u_rc_ram (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(in_read_count),
    .raddr(rc_raddr), .rdata(rc_rdata)
  );

  ris_ram #(.WIDTH(ris_pkg::KEY_W), .DEPTH(MAX_RECORDS)) u_mom_ram (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(in_momentum),
    .raddr(key_raddr), .rdata(mom_rdata)
  );

  ris_ram #(.WIDTH(ris_pkg::KEY_W), .DEPTH(MAX_RECORDS)) u_time_ram (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(in_created_time),
    .raddr(key_raddr), .rdata(time_rdata)
  );

  ris_ram #(.WIDTH(IDX_W), .DEPTH(MAX_RECORDS)) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  always_comb begin
    count_ext = (CNT_W + 1)'(count_r);
    i_ext     = (CNT_W + 1)'(i_r);
    j_ext     = (CNT_W + 1)'(j_r);

    stat.part     = (mode_r == ris_pkg::MODE_READ_FIRST);
    stat.keyed    = (mode_r inside {ris_pkg::MODE_MOMENTUM, ris_pkg::MODE_TIME_DESC,
                                    ris_pkg::MODE_TIME_ASC});
    stat.empty    = (count_r == '0);
    stat.one_rec  = (count_r == CNT_W'(1));
    stat.i_last   = (i_ext + (CNT_W + 1)'(1) == count_ext);
    stat.i_penult = (i_ext + (CNT_W + 1)'(2) == count_ext);
    stat.j_last   = (j_ext + (CNT_W + 1)'(1) == count_ext);
    stat.pass     = pass_r;
  end

  always_comb begin
    key_sel = (mode_r == ris_pkg::MODE_MOMENTUM) ? mom_rdata : time_rdata;
    better  = (mode_r == ris_pkg::MODE_TIME_ASC) ? (key_sel < cur_key_r)
                                                 : (key_sel > cur_key_r);
    full    = (count_r == CNT_W'(MAX_RECORDS));
    match   = pass_r ? (rc_rdata == '0) : (rc_rdata != '0);

    count_nxt   = count_r;
    mode_nxt    = cfg_we ? cfg_wdata : mode_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    pass_nxt    = pass_r;
    pos_bad_nxt = pos_bad_r;
    cur_idx_nxt = cur_idx_r;
    cur_key_nxt = cur_key_r;
    cand_nxt    = cand_r;
    oidx_nxt    = oidx_r;
    otot_nxt    = otot_r;
    ost_nxt     = ost_r;
    load        = 1'b0;

    rec_we    = 1'b0;
    rec_waddr = count_r[IDX_W-1:0];
    rc_raddr  = i_r[IDX_W-1:0];
    key_raddr = ord_rdata;
    ord_we    = 1'b0;
    ord_waddr = i_r[IDX_W-1:0];
    ord_wdata = cur_idx_r;
    ord_raddr = i_r[IDX_W-1:0];

    case (cmd.op)
      ris_pkg::OP_CLEAR: begin
        count_nxt = '0;
        load      = 1'b1;
        oidx_nxt  = '0;
        ost_nxt   = ris_pkg::ST_OK;
      end
      ris_pkg::OP_APPEND: begin
        load     = 1'b1;
        oidx_nxt = '0;
        if (full) begin
          ost_nxt = ris_pkg::ST_FULL;
        end else begin
          rec_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          ost_nxt   = ris_pkg::ST_OK;
        end
      end
      ris_pkg::OP_READ_ISSUE: begin
        ord_raddr   = IDX_W'(in_position);
        pos_bad_nxt = (CMP_W'(in_position) >= CMP_W'(count_r));
      end
      ris_pkg::OP_READ_DONE: begin
        load = 1'b1;
        if (pos_bad_r) begin
          oidx_nxt = '0;
          ost_nxt  = ris_pkg::ST_BEYOND;
        end else begin
          oidx_nxt = ris_pkg::IDXO_W'(ord_rdata);
          ost_nxt  = ris_pkg::ST_OK;
        end
      end
      ris_pkg::OP_SORT_START: begin
        i_nxt    = '0;
        k_nxt    = '0;
        pass_nxt = 1'b0;
      end
      ris_pkg::OP_INIT_WR: begin
        ord_we    = 1'b1;
        ord_wdata = i_r[IDX_W-1:0];
        i_nxt     = stat.i_last ? '0 : i_r + CNT_W'(1);
      end
      ris_pkg::OP_P0_RD: begin
        rc_raddr = i_r[IDX_W-1:0];
      end
      ris_pkg::OP_P0_WR: begin
        if (match) begin
          ord_we    = 1'b1;
          ord_waddr = k_r[IDX_W-1:0];
          ord_wdata = i_r[IDX_W-1:0];
          k_nxt     = k_r + CNT_W'(1);
        end
        i_nxt    = stat.i_last ? '0 : i_r + CNT_W'(1);
        pass_nxt = pass_r ^ stat.i_last;
      end
      ris_pkg::OP_OI_RD: begin
        ord_raddr = i_r[IDX_W-1:0];
      end
      ris_pkg::OP_OI_KEY: begin
        cand_nxt = ord_rdata;
      end
      ris_pkg::OP_OI_LOAD: begin
        cur_idx_nxt = cand_r;
        cur_key_nxt = key_sel;
        j_nxt       = i_r + CNT_W'(1);
      end
      ris_pkg::OP_J_RD: begin
        ord_raddr = j_r[IDX_W-1:0];
      end
      ris_pkg::OP_J_KEY: begin
        cand_nxt = ord_rdata;
      end
      ris_pkg::OP_J_CMP: begin
        if (better) begin
          ord_we      = 1'b1;
          ord_waddr   = j_r[IDX_W-1:0];
          ord_wdata   = cur_idx_r;
          cur_idx_nxt = cand_r;
          cur_key_nxt = key_sel;
        end
        j_nxt = j_r + CNT_W'(1);
      end
      ris_pkg::OP_I_WR: begin
        ord_we    = 1'b1;
        ord_waddr = i_r[IDX_W-1:0];
        ord_wdata = cur_idx_r;
        i_nxt     = i_r + CNT_W'(1);
      end
      ris_pkg::OP_SORT_DONE: begin
        load     = 1'b1;
        oidx_nxt = '0;
        ost_nxt  = ris_pkg::ST_OK;
      end
      default: begin
      end
    endcase

    if (load) begin
      otot_nxt = ris_pkg::TOTAL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      mode_r    <= ris_pkg::MODE_RESET;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      pass_r    <= 1'b0;
      pos_bad_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      mode_r    <= mode_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      k_r       <= k_nxt;
      pass_r    <= pass_nxt;
      pos_bad_r <= pos_bad_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_idx_r <= cur_idx_nxt;
    cur_key_r <= cur_key_nxt;
    cand_r    <= cand_nxt;
    oidx_r    <= oidx_nxt;
    otot_r    <= otot_nxt;
    ost_r     <= ost_nxt;
  end

  assign out_record_index = oidx_r;
  assign out_entry_total  = otot_r;
  assign out_status       = ost_r;

endmodule

### rtl/core/ris_ctrl.sv
// ----------------------------------------------------------------------------
// ris_ctrl
// Controller of the record index sorter: input and result handshake and
// the sequencer for the sort passes.
// ----------------------------------------------------------------------------
module ris_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ris_pkg::CMD_W-1:0]   in_cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ris_pkg::ris_cmd_t           cmd,
  input  ris_pkg::ris_stat_t          stat
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_RD_WAIT = 13'b0000000000010,
    S_INIT    = 13'b0000000000100,
    S_P0_RD   = 13'b0000000001000,
    S_P0_WR   = 13'b0000000010000,
    S_OI_RD   = 13'b0000000100000,
    S_OI_KEY  = 13'b0000001000000,
    S_OI_LOAD = 13'b0000010000000,
    S_J_RD    = 13'b0000100000000,
    S_J_KEY   = 13'b0001000000000,
    S_J_CMP   = 13'b0010000000000,
    S_I_WR    = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   load;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = ris_pkg::OP_NONE;
    load      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            ris_pkg::CMD_CLEAR: begin
              cmd.op = ris_pkg::OP_CLEAR;
              load   = 1'b1;
            end
            ris_pkg::CMD_APPEND: begin
              cmd.op = ris_pkg::OP_APPEND;
              load   = 1'b1;
            end
            ris_pkg::CMD_SORT: begin
              cmd.op = ris_pkg::OP_SORT_START;
              if (stat.empty) begin
                state_nxt = S_DONE;
              end else if (stat.part) begin
                state_nxt = S_P0_RD;
              end else begin
                state_nxt = S_INIT;
              end
            end
            default: begin
              cmd.op    = ris_pkg::OP_READ_ISSUE;
              state_nxt = S_RD_WAIT;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd.op    = ris_pkg::OP_READ_DONE;
        load      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        cmd.op = ris_pkg::OP_INIT_WR;
        if (stat.i_last) begin
          state_nxt = (stat.keyed && !stat.one_rec) ? S_OI_RD : S_DONE;
        end
      end
      S_P0_RD: begin
        cmd.op    = ris_pkg::OP_P0_RD;
        state_nxt = S_P0_WR;
      end
      S_P0_WR: begin
        cmd.op    = ris_pkg::OP_P0_WR;
        state_nxt = (stat.i_last && stat.pass) ? S_DONE : S_P0_RD;
      end
      S_OI_RD: begin
        cmd.op    = ris_pkg::OP_OI_RD;
        state_nxt = S_OI_KEY;
      end
      S_OI_KEY: begin
        cmd.op    = ris_pkg::OP_OI_KEY;
        state_nxt = S_OI_LOAD;
      end
      S_OI_LOAD: begin
        cmd.op    = ris_pkg::OP_OI_LOAD;
        state_nxt = S_J_RD;
      end
      S_J_RD: begin
        cmd.op    = ris_pkg::OP_J_RD;
        state_nxt = S_J_KEY;
      end
      S_J_KEY: begin
        cmd.op    = ris_pkg::OP_J_KEY;
        state_nxt = S_J_CMP;
      end
      S_J_CMP: begin
        cmd.op    = ris_pkg::OP_J_CMP;
        state_nxt = stat.j_last ? S_I_WR : S_J_RD;
      end
      S_I_WR: begin
        cmd.op    = ris_pkg::OP_I_WR;
        state_nxt = stat.i_penult ? S_DONE : S_OI_RD;
      end
      S_DONE: begin
        cmd.op    = ris_pkg::OP_SORT_DONE;
        load      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/record_index_sorter_unit.sv
// ----------------------------------------------------------------------------
// record_index_sorter_unit
// Record table with a multi-key index sort and ranked read-back.
// ----------------------------------------------------------------------------
// Usage:
//   in_* is a valid/ready channel carrying one command item; out_* returns
//   one result item per command. cfg_we/cfg_wdata write the sort mode.
//   The result of a clear or append is in the output register in the cycle
//   after it is taken. A read passes the order store read and the read wait
//   state. A sort runs from the controller's sequencer:
//     read first mode  : start, two passes over the read counts, done
//     load order       : start, index fill, done
//     keyed modes      : start, index fill, then an exchange pass per position
//                        built of compare steps (order read, key read,
//                        compare and swap), done
//   An empty sort goes from the start step straight to done.
//   in_ready is low while a sort or read runs and while a result waits with
//   out_ready low; the result register holds until it is taken.
//   Reset clears the record count, the result valid and sets the mode to
//   momentum descending; the stores are not cleared.
// ----------------------------------------------------------------------------
module record_index_sorter_unit #(
  parameter int MAX_RECORDS = ris_pkg::MAX_RECORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ris_pkg::MODE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ris_pkg::CMD_W-1:0]     in_cmd,
  input  logic [ris_pkg::RC_W-1:0]      in_read_count,
  input  logic [ris_pkg::KEY_W-1:0]     in_momentum,
  input  logic [ris_pkg::KEY_W-1:0]     in_created_time,
  input  logic [ris_pkg::POS_W-1:0]     in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ris_pkg::IDXO_W-1:0]    out_record_index,
  output logic [ris_pkg::TOTAL_W-1:0]   out_entry_total,
  output logic [ris_pkg::STATUS_W-1:0]  out_status
);

  ris_pkg::ris_cmd_t  cmd;
  ris_pkg::ris_stat_t stat;

  ris_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ris_datapath #(.MAX_RECORDS(MAX_RECORDS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_read_count    (in_read_count),
    .in_momentum      (in_momentum),
    .in_created_time  (in_created_time),
    .in_position      (in_position),
    .cmd              (cmd),
    .stat             (stat),
    .out_record_index (out_record_index),
    .out_entry_total  (out_entry_total),
    .out_status       (out_status)
  );

endmodule

### rtl/core/ris_checker.sv
// ----------------------------------------------------------------------------
// ris_checker
// Port-level checks of the record index sorter, bound to the top level.
// ----------------------------------------------------------------------------
module ris_checker #(
  parameter int MAX_RECORDS = ris_pkg::MAX_RECORDS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ris_pkg::IDXO_W-1:0]    out_record_index,
  input logic [ris_pkg::TOTAL_W-1:0]   out_entry_total,
  input logic [ris_pkg::STATUS_W-1:0]  out_status
);

  // no result pending right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a new item is never taken while a result is stalled
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("item accepted while result stalled");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_record_index)
      && $stable(out_entry_total) && $stable(out_status)))
    else $error("stalled result changed");

  // failed read returns index zero
  a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ris_pkg::ST_BEYOND) |-> (out_record_index == '0))
    else $error("nonzero index on failed read");

  // count never exceeds table size
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_entry_total) <= 32'(MAX_RECORDS)))
    else $error("entry total beyond table size");

endmodule

bind record_index_sorter_unit ris_checker #(.MAX_RECORDS(MAX_RECORDS)) u_ris_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_record_index (out_record_index),
  .out_entry_total  (out_entry_total),
  .out_status       (out_status)
);
